>>> src/pps_pkg.sv
// ----------------------------------------------------------------------------
// pps_pkg
// shared types and constants of the pure pursuit steering block
// ----------------------------------------------------------------------------
package pps_pkg;

    localparam int PATH_DEPTH        = 256;
    localparam int IDX_W             = $clog2(PATH_DEPTH);
    localparam int CNT_W             = $clog2(PATH_DEPTH + 1);
    localparam int CORDIC_ITERATIONS = 16;
    localparam int IT_W              = $clog2(CORDIC_ITERATIONS + 1);
    localparam logic [29:0] INV_GAIN_Q30 = 30'd652032874;

    typedef enum logic [1:0] {
        CMD_CLEAR   = 2'd0,
        CMD_APPEND  = 2'd1,
        CMD_POSE    = 2'd2,
        CMD_COMPUTE = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        REG_LOOKAHEAD = 2'd0,
        REG_GOAL_TOL  = 2'd1,
        REG_CRUISE    = 2'd2,
        REG_MAX_TURN  = 2'd3
    } reg_idx_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_GOAL_RD,
        ST_GOAL_SQ,
        ST_GOAL_CHK,
        ST_NEAR_RD,
        ST_NEAR_SQ,
        ST_NEAR_CHK,
        ST_LOOK_RD,
        ST_LOOK_SQ,
        ST_LOOK_CHK,
        ST_TGT_RD,
        ST_TGT_OFS,
        ST_SCALE,
        ST_YAW1,
        ST_YAW2,
        ST_PRE,
        ST_CORDIC,
        ST_ROUND,
        ST_R2,
        ST_PROD,
        ST_LIM,
        ST_DIV,
        ST_DONE,
        ST_OUT
    } state_t;

endpackage

>>> src/pps_divider.sv
// ----------------------------------------------------------------------------
// pps_divider
// restoring divider, one quotient bit per cycle, 24 bit quotient
// ----------------------------------------------------------------------------
module pps_divider
    import pps_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [127:0] num,
    input  logic [64:0]  den,
    output logic         busy,
    output logic [23:0]  quot
);

    logic [127:0] rem_reg, rem_next;
    logic [23:0]  q_reg, q_next;
    logic [64:0]  den_reg, den_next;
    logic [4:0]   bit_reg, bit_next;
    logic         busy_reg, busy_next;
    logic [127:0] sh;

    assign sh = {63'd0, den_reg} << bit_reg;

    always_comb
    begin
        rem_next  = rem_reg;
        q_next    = q_reg;
        den_next  = den_reg;
        bit_next  = bit_reg;
        busy_next = busy_reg;
        if (start)
        begin
            rem_next  = num;
            den_next  = den;
            q_next    = '0;
            bit_next  = 5'd23;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (rem_reg >= sh)
            begin
                rem_next        = rem_reg - sh;
                q_next[bit_reg] = 1'b1;
            end
            if (bit_reg == 5'd0)
                busy_next = 1'b0;
            else
                bit_next = bit_reg - 5'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            busy_reg <= 1'b0;
        else
            busy_reg <= busy_next;
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        q_reg   <= q_next;
        den_reg <= den_next;
        bit_reg <= bit_next;
    end

    assign busy = busy_reg;
    assign quot = q_reg;

endmodule

>>> src/pure_pursuit_steering_top.sv
// ----------------------------------------------------------------------------
// pure_pursuit_steering_top
// pure pursuit path follower with waypoint store, cordic yaw and divider
// ----------------------------------------------------------------------------
// channel   direction  handshake                 payload
// in        input      in_valid / in_ready       command, pos, quat
// out       output     out_valid / out_ready     success, velocities
// cfg       input      cfg_we                    cfg_index, cfg_data
//
// clear, append and pose are accepted while idle and give no transaction out.
// compute runs at most two scans of the waypoint memory, 16 cordic steps and
// 24 divide steps; no pose or an empty path goes straight to the result.
// in_ready is low from acceptance of a compute until its result is taken.
// reset clears pose and count and sets the registers to their defaults; the waypoint memory is not cleared.
// ----------------------------------------------------------------------------
module pure_pursuit_steering_top
    import pps_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         command,
    input  logic signed [31:0] pos_x,
    input  logic signed [31:0] pos_y,
    input  logic signed [15:0] quat_x,
    input  logic signed [15:0] quat_y,
    input  logic signed [15:0] quat_z,
    input  logic signed [15:0] quat_w,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               success,
    output logic [23:0]        linear_velocity,
    output logic signed [24:0] angular_velocity,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [23:0]        cfg_data
);

    state_t state_reg, state_next;

    logic [23:0] look_reg, tol_reg, cruise_reg, turn_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic signed [31:0] rx_reg, ry_reg;
    logic signed [15:0] qx_reg, qy_reg, qz_reg, qw_reg;
    logic pose_reg;

    // waypoint memory
    logic [63:0] wp_mem [PATH_DEPTH];
    logic [63:0] rd_reg;
    logic [IDX_W-1:0] rd_addr;

    logic [CNT_W-1:0] i_reg, i_next, best_reg, best_next, tgt_reg, tgt_next;
    logic [64:0] bd_reg, bd_next, d_reg;
    logic signed [32:0] ex_reg, ey_reg;
    logic signed [63:0] px_reg, px_next, py_reg, py_next;
    logic signed [63:0] c_reg, c_next, s_reg, s_next;
    logic signed [33:0] t1_reg, t2_reg;
    logic [IT_W-1:0] it_reg, it_next;
    logic signed [33:0] xr_reg, yr_reg;
    logic [64:0] r2_reg;
    logic [127:0] num_reg, lim_reg;
    logic ok_reg, ok_next;
    logic [23:0] lin_reg, lin_next;
    logic signed [24:0] ang_reg, ang_next;
    logic div_start;
    logic div_busy;
    logic [23:0] div_q;

    logic in_acc;
    assign in_acc = in_valid && in_ready;

    // squared distance of the read waypoint to the robot
    logic signed [32:0] ddx, ddy;
    logic [32:0] adx, ady;
    assign ddx = 33'(signed'(rd_reg[63:32])) - 33'(rx_reg);
    assign ddy = 33'(signed'(rd_reg[31:0])) - 33'(ry_reg);
    assign adx = ddx[32] ? 33'(-ddx) : 33'(ddx);
    assign ady = ddy[32] ? 33'(-ddy) : 33'(ddy);

    always_ff @(posedge clk)
    begin
        d_reg <= 65'({1'b0, adx} * {1'b0, adx}) + 65'({1'b0, ady} * {1'b0, ady});
    end

    always_comb
    begin
        unique case (state_reg)
            ST_GOAL_RD: rd_addr = IDX_W'(cnt_reg - CNT_W'(1));
            ST_TGT_RD:  rd_addr = tgt_reg[IDX_W-1:0];
            default:    rd_addr = i_reg[IDX_W-1:0];
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (in_acc && cmd_t'(command) == CMD_APPEND && cnt_reg < CNT_W'(PATH_DEPTH))
            wp_mem[cnt_reg[IDX_W-1:0]] <= {pos_x, pos_y};
        rd_reg <= wp_mem[rd_addr];
    end

    // pose, count and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            look_reg   <= 24'd65536;
            tol_reg    <= 24'd13107;
            cruise_reg <= 24'd32768;
            turn_reg   <= 24'd65536;
            cnt_reg    <= '0;
            pose_reg   <= 1'b0;
            rx_reg     <= '0;
            ry_reg     <= '0;
            qx_reg     <= '0;
            qy_reg     <= '0;
            qz_reg     <= '0;
            qw_reg     <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (reg_idx_t'(cfg_index))
                    REG_LOOKAHEAD: if (cfg_data != '0) look_reg <= cfg_data;
                    REG_GOAL_TOL:  if (cfg_data != '0) tol_reg <= cfg_data;
                    REG_CRUISE:    cruise_reg <= cfg_data;
                    REG_MAX_TURN:  if (cfg_data != '0) turn_reg <= cfg_data;
                endcase
            end
            if (in_acc)
            begin
                unique case (cmd_t'(command))
                    CMD_CLEAR:  cnt_reg <= '0;
                    CMD_APPEND: if (cnt_reg < CNT_W'(PATH_DEPTH)) cnt_reg <= cnt_reg + CNT_W'(1);
                    CMD_POSE:
                    begin
                        rx_reg   <= pos_x;
                        ry_reg   <= pos_y;
                        qx_reg   <= quat_x;
                        qy_reg   <= quat_y;
                        qz_reg   <= quat_z;
                        qw_reg   <= quat_w;
                        pose_reg <= 1'b1;
                    end
                    CMD_COMPUTE: ;
                endcase
            end
        end
    end

    logic [47:0] tol2, look2;
    assign tol2  = tol_reg * tol_reg;
    assign look2 = look_reg * look_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (in_acc && cmd_t'(command) == CMD_COMPUTE)
                    state_next = (!pose_reg || cnt_reg == '0) ? ST_OUT : ST_GOAL_RD;
            ST_GOAL_RD:  state_next = ST_GOAL_SQ;
            ST_GOAL_SQ:  state_next = ST_GOAL_CHK;
            ST_GOAL_CHK: state_next = (65'(tol2) >= d_reg) ? ST_OUT : ST_NEAR_RD;
            ST_NEAR_RD:  state_next = ST_NEAR_SQ;
            ST_NEAR_SQ:  state_next = ST_NEAR_CHK;
            ST_NEAR_CHK: state_next = (i_reg + CNT_W'(1) >= cnt_reg) ? ST_LOOK_RD : ST_NEAR_RD;
            ST_LOOK_RD:  state_next = ST_LOOK_SQ;
            ST_LOOK_SQ:  state_next = ST_LOOK_CHK;
            ST_LOOK_CHK:
                state_next = (d_reg >= 65'(look2) || i_reg + CNT_W'(1) >= cnt_reg)
                             ? ST_TGT_RD : ST_LOOK_RD;
            ST_TGT_RD:   state_next = ST_TGT_OFS;
            ST_TGT_OFS:  state_next = ST_SCALE;
            ST_SCALE:    state_next = ST_YAW1;
            ST_YAW1:     state_next = ST_YAW2;
            ST_YAW2:     state_next = ST_PRE;
            ST_PRE:      state_next = ST_CORDIC;
            ST_CORDIC:
                if (it_reg == IT_W'(CORDIC_ITERATIONS - 1)) state_next = ST_ROUND;
            ST_ROUND:    state_next = ST_R2;
            ST_R2:       state_next = xr_reg[33] ? ST_OUT : ST_PROD;
            ST_PROD:     state_next = ST_LIM;
            ST_LIM:
                if (r2_reg == '0 || num_reg >= lim_reg) state_next = ST_OUT;
                else state_next = ST_DIV;
            ST_DIV:      state_next = ST_DONE;
            ST_DONE:     if (!div_busy) state_next = ST_OUT;
            ST_OUT:      if (out_ready) state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    // cordic micro-rotation
    logic signed [63:0] sc, ss, spx, spy;
    logic [5:0] sh_n;
    assign sh_n = 6'(it_reg);
    assign sc  = c_reg >>> sh_n;
    assign ss  = s_reg >>> sh_n;
    assign spx = px_reg >>> sh_n;
    assign spy = py_reg >>> sh_n;

    logic signed [63:0] yaw_s, yaw_c;
    assign yaw_s = 64'(t1_reg) <<< 1;
    assign yaw_c = (64'sd1 <<< 30) - (64'(t2_reg) <<< 1);

    logic signed [63:0] xr_full, yr_full;
    assign xr_full = (px_reg + (64'sd1 <<< 29)) >>> 30;
    assign yr_full = (py_reg + (64'sd1 <<< 29)) >>> 30;

    logic [33:0] axr, ayr;
    assign axr = xr_reg[33] ? 34'(-xr_reg) : 34'(xr_reg);
    assign ayr = yr_reg[33] ? 34'(-yr_reg) : 34'(yr_reg);

    logic signed [24:0] turn_s;
    assign turn_s = 25'(turn_reg);

    // datapath and outputs
    always_comb
    begin
        i_next    = i_reg;
        best_next = best_reg;
        tgt_next  = tgt_reg;
        bd_next   = bd_reg;
        px_next   = px_reg;
        py_next   = py_reg;
        c_next    = c_reg;
        s_next    = s_reg;
        it_next   = it_reg;
        ok_next   = ok_reg;
        lin_next  = lin_reg;
        ang_next  = ang_reg;
        div_start = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                i_next    = '0;
                best_next = '0;
                ok_next   = pose_reg;
                lin_next  = '0;
                ang_next  = '0;
            end
            ST_GOAL_CHK: bd_next = '1;
            ST_NEAR_CHK:
            begin
                if (d_reg < bd_reg)
                begin
                    bd_next   = d_reg;
                    best_next = i_reg;
                end
                if (i_reg + CNT_W'(1) >= cnt_reg)
                    i_next = (d_reg < bd_reg) ? i_reg : best_reg;
                else
                    i_next = i_reg + CNT_W'(1);
            end
            ST_LOOK_CHK:
            begin
                tgt_next = (d_reg >= 65'(look2)) ? i_reg : cnt_reg - CNT_W'(1);
                i_next   = i_reg + CNT_W'(1);
            end
            ST_SCALE:
            begin
                px_next = 64'(ex_reg * signed'({1'b0, INV_GAIN_Q30}));
                py_next = 64'(ey_reg * signed'({1'b0, INV_GAIN_Q30}));
            end
            ST_PRE:
            begin
                c_next = yaw_c;
                s_next = yaw_s;
                if (yaw_c == '0 && yaw_s == '0)
                    c_next = 64'sd1 <<< 30;
                else if (yaw_c < 0)
                begin
                    if (yaw_s >= 0)
                    begin
                        c_next  = yaw_s;
                        s_next  = -yaw_c;
                        px_next = py_reg;
                        py_next = -px_reg;
                    end
                    else
                    begin
                        c_next  = -yaw_s;
                        s_next  = yaw_c;
                        px_next = -py_reg;
                        py_next = px_reg;
                    end
                end
                it_next = '0;
            end
            ST_CORDIC:
            begin
                if (s_reg >= 0)
                begin
                    c_next  = c_reg + ss;
                    s_next  = s_reg - sc;
                    px_next = px_reg + spy;
                    py_next = py_reg - spx;
                end
                else
                begin
                    c_next  = c_reg - ss;
                    s_next  = s_reg + sc;
                    px_next = px_reg - spy;
                    py_next = py_reg + spx;
                end
                it_next = it_reg + IT_W'(1);
            end
            ST_R2:
                if (xr_reg[33])
                    ang_next = (yr_reg > 0) ? turn_s : -turn_s;
            ST_LIM:
            begin
                if (r2_reg == '0)
                    ok_next = 1'b0;
                else
                begin
                    lin_next = cruise_reg;
                    if (num_reg >= lim_reg)
                        ang_next = yr_reg[33] ? -turn_s : turn_s;
                end
            end
            ST_DIV: div_start = 1'b1;
            ST_DONE:
                if (!div_busy)
                    ang_next = yr_reg[33] ? -25'(div_q) : 25'(div_q);
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        i_reg    <= i_next;
        best_reg <= best_next;
        tgt_reg  <= tgt_next;
        bd_reg   <= bd_next;
        c_reg    <= c_next;
        s_reg    <= s_next;
        it_reg   <= it_next;
        ok_reg   <= ok_next;
        lin_reg  <= lin_next;
        ang_reg  <= ang_next;
        px_reg   <= px_next;
        py_reg   <= py_next;
        unique case (state_reg)
            ST_TGT_OFS:
            begin
                ex_reg <= 33'(signed'(rd_reg[63:32])) - 33'(rx_reg);
                ey_reg <= 33'(signed'(rd_reg[31:0])) - 33'(ry_reg);
            end
            ST_YAW1:
            begin
                t1_reg <= 34'(qw_reg * qz_reg) + 34'(qx_reg * qy_reg);
                t2_reg <= 34'(qy_reg * qy_reg) + 34'(qz_reg * qz_reg);
            end
            ST_ROUND:
            begin
                xr_reg <= 34'(xr_full);
                yr_reg <= 34'(yr_full);
            end
            ST_R2:
            begin
                r2_reg  <= 65'(axr * axr) + 65'(ayr * ayr);
                num_reg <= 128'({cruise_reg, 17'd0} * ayr);
            end
            default: ;
        endcase
        lim_reg <= 128'(r2_reg * turn_reg);
    end

    pps_divider u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (num_reg),
        .den   (r2_reg),
        .busy  (div_busy),
        .quot  (div_q)
    );

    assign in_ready         = (state_reg == ST_IDLE);
    assign out_valid        = (state_reg == ST_OUT);
    assign success          = ok_reg;
    assign linear_velocity  = lin_reg;
    assign angular_velocity = ang_reg;

    a_no_out_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("result and input both open");
    a_out_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(angular_velocity))
        else $error("result dropped while stalled");
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !success |-> linear_velocity == '0 && angular_velocity == '0)
        else $error("fail result carries speed");
    a_turn_clamp: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (angular_velocity <= turn_s) && (angular_velocity >= -turn_s))
        else $error("turn rate exceeds limit");

endmodule

>>> sim/tb_pure_pursuit_steering_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_pure_pursuit_steering_top
// self-checking bench for the pure pursuit steering block: a directed table
// followed by random path / pose / compute sequences over several register
// settings, each result compared against a typed row result or a behavioural steering predictor
// ----------------------------------------------------------------------------
module tb_pure_pursuit_steering_top;
    import pps_pkg::*;

    typedef struct {
        cmd_t               cmd;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [15:0] qx;
        logic signed [15:0] qy;
        logic signed [15:0] qz;
        logic signed [15:0] qw;
    } cmd_item_t;

    typedef struct {
        logic               ok;
        logic [23:0]        lin;
        logic signed [24:0] ang;
    } steer_t;

    typedef struct {
        cmd_item_t it;
        bit        typed;
        steer_t    r;
    } row_t;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic [1:0]         command;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
    logic signed [15:0] quat_w;
    logic               out_valid;
    logic               out_ready;
    logic               success;
    logic [23:0]        linear_velocity;
    logic signed [24:0] angular_velocity;
    logic               cfg_we;
    logic [1:0]         cfg_index;
    logic [23:0]        cfg_data;

    pure_pursuit_steering_top uut (.*);

    // predictor copy of the block state
    longint  path_x [PATH_DEPTH];
    longint  path_y [PATH_DEPTH];
    int      path_len;
    longint  pose_x, pose_y;
    longint  ori [4];
    bit      have_pose;
    longint  look_reg, tol_reg, cruise_reg, turn_reg;

    steer_t  steer_q [$];
    int      mismatches;
    int      results_seen;
    int      computes_sent;
    int      items_sent;
    bit      calm;
    int      out_stall;

    initial clk = 1'b0;
    always #1 clk = ~clk;

    function automatic logic [127:0] sq_range(longint ax, longint ay, longint bx, longint by);
        longint dx, dy;
        logic [127:0] ux, uy;
        dx = ax - bx;
        dy = ay - by;
        if (dx < 0) dx = -dx;
        if (dy < 0) dy = -dy;
        ux = 128'(unsigned'(dx));
        uy = 128'(unsigned'(dy));
        return ux * ux + uy * uy;
    endfunction

    function automatic steer_t steer_make(logic ok, longint lin, longint ang);
        steer_t r;
        r.ok  = ok;
        r.lin = lin[23:0];
        r.ang = ang[24:0];
        return r;
    endfunction

    function automatic steer_t pursue_target();
        int n, best, tgt;
        logic [127:0] bd, d, l2, r2, num, lim, q, ux, uy;
        longint dx, dy, px, py, c, s, t, nc, ns, npx, npy, xr, yr;
        n = path_len;
        if (!have_pose) return steer_make(0, 0, 0);
        if (n == 0) return steer_make(1, 0, 0);
        if (128'(tol_reg) * 128'(tol_reg) >=
            sq_range(pose_x, pose_y, path_x[n-1], path_y[n-1]))
            return steer_make(1, 0, 0);
        best = 0;
        bd = sq_range(pose_x, pose_y, path_x[0], path_y[0]);
        for (int i = 1; i < n; i++) begin
            d = sq_range(pose_x, pose_y, path_x[i], path_y[i]);
            if (d < bd) begin
                bd = d;
                best = i;
            end
        end
        l2 = 128'(look_reg) * 128'(look_reg);
        tgt = n - 1;
        for (int i = best; i < n; i++) begin
            if (sq_range(pose_x, pose_y, path_x[i], path_y[i]) >= l2) begin
                tgt = i;
                break;
            end
        end
        dx = path_x[tgt] - pose_x;
        dy = path_y[tgt] - pose_y;
        px = dx * 64'sd652032874;
        py = dy * 64'sd652032874;
        s = 2 * (ori[3] * ori[2] + ori[0] * ori[1]);
        c = (64'sd1 <<< 30) - 2 * (ori[1] * ori[1] + ori[2] * ori[2]);
        // yaw undefined: treat as facing along x
        if (c == 0 && s == 0) c = 64'sd1 <<< 30;
        if (c < 0) begin
            if (s >= 0) begin
                t = c; c = s; s = -t; t = px; px = py; py = -t;
            end
            else begin
                t = c; c = -s; s = t; t = px; px = -py; py = t;
            end
        end
        for (int i = 0; i < CORDIC_ITERATIONS; i++) begin
            if (s >= 0) begin
                nc = c + (s >>> i); ns = s - (c >>> i);
                npx = px + (py >>> i); npy = py - (px >>> i);
            end
            else begin
                nc = c - (s >>> i); ns = s + (c >>> i);
                npx = px - (py >>> i); npy = py + (px >>> i);
            end
            c = nc; s = ns; px = npx; py = npy;
        end
        xr = (px + (64'sd1 <<< 29)) >>> 30;
        yr = (py + (64'sd1 <<< 29)) >>> 30;
        // target behind: turn in place
        if (xr < 0) return steer_make(1, 0, (yr > 0) ? turn_reg : -turn_reg);
        ux = 128'(unsigned'(xr));
        uy = 128'(unsigned'(yr < 0 ? -yr : yr));
        r2 = ux * ux + uy * uy;
        if (r2 == 0) return steer_make(0, 0, 0);
        num = (128'(cruise_reg) << 17) * uy;
        lim = r2 * 128'(turn_reg);
        if (num >= lim) q = 128'(turn_reg);
        else q = num / r2;
        return steer_make(1, cruise_reg, (yr < 0) ? -longint'(q[63:0]) : longint'(q[63:0]));
    endfunction

    function automatic bit steer_apply(cmd_item_t it, output steer_t r);
        r = steer_make(0, 0, 0);
        case (it.cmd)
            CMD_CLEAR: path_len = 0;
            CMD_APPEND:
                if (path_len < PATH_DEPTH) begin
                    path_x[path_len] = it.x;
                    path_y[path_len] = it.y;
                    path_len++;
                end
            CMD_POSE: begin
                pose_x = it.x;
                pose_y = it.y;
                ori[0] = it.qx; ori[1] = it.qy; ori[2] = it.qz; ori[3] = it.qw;
                have_pose = 1'b1;
            end
            default: begin
                r = pursue_target();
                return 1'b1;
            end
        endcase
        return 1'b0;
    endfunction

    // out side: random stall bursts
    always @(negedge clk)
    begin
        if (out_stall > 0) begin
            out_stall <= out_stall - 1;
            out_ready <= 1'b0;
        end
        else if (!calm && $urandom_range(0, 5) == 0) begin
            out_stall <= $urandom_range(0, 16);
            out_ready <= 1'b0;
        end
        else begin
            out_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready) begin
            steer_t e;
            results_seen++;
            if (steer_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected transaction out: ok %0d lin %0d ang %0d",
                             success, linear_velocity, angular_velocity);
            end
            else begin
                e = steer_q.pop_front();
                if (success !== e.ok || linear_velocity !== e.lin ||
                    angular_velocity !== e.ang) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp ok %0d lin %0d ang %0d, got ok %0d lin %0d ang %0d",
                                 e.ok, e.lin, e.ang, success, linear_velocity,
                                 angular_velocity);
                end
            end
        end
    end

    // called at a falling edge; returns at the falling edge after acceptance
    task automatic send_txn(cmd_item_t it, bit typed, steer_t typ);
        steer_t r;
        if (!calm && $urandom_range(0, 3) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(negedge clk);
        end
        command  <= it.cmd;
        pos_x    <= it.x;
        pos_y    <= it.y;
        quat_x   <= it.qx;
        quat_y   <= it.qy;
        quat_z   <= it.qz;
        quat_w   <= it.qw;
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        items_sent++;
        if (steer_apply(it, r)) begin
            computes_sent++;
            steer_q.push_back(typed ? typ : r);
        end
        @(negedge clk);
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        wait (steer_q.size() == 0);
        repeat (16) @(negedge clk);
    endtask

    task automatic write_reg(reg_idx_t idx, logic [23:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            REG_LOOKAHEAD: if (val != 0) look_reg = val;
            REG_GOAL_TOL:  if (val != 0) tol_reg = val;
            REG_CRUISE:    cruise_reg = val;
            default:       if (val != 0) turn_reg = val;
        endcase
    endtask

    function automatic cmd_item_t mk(cmd_t cmd, longint x, longint y,
                                     int qx, int qy, int qz, int qw);
        cmd_item_t it;
        it.cmd = cmd;
        it.x = x[31:0]; it.y = y[31:0];
        it.qx = qx[15:0]; it.qy = qy[15:0]; it.qz = qz[15:0]; it.qw = qw[15:0];
        return it;
    endfunction

    function automatic logic signed [31:0] rnd_coord(int sh);
        if (sh >= 31) return $urandom;
        return $signed($urandom) >>> (31 - sh);
    endfunction

    function automatic cmd_item_t rnd_noise();
        cmd_item_t it;
        it.cmd = cmd_t'($urandom_range(0, 3));
        it.x = $urandom; it.y = $urandom;
        it.qx = 16'($urandom); it.qy = 16'($urandom);
        it.qz = 16'($urandom); it.qw = 16'($urandom);
        return it;
    endfunction

    task automatic random_phase(int quota);
        int done, k, sh;
        longint bx, by;
        cmd_item_t it;
        steer_t none;
        none = steer_make(0, 0, 0);
        done = 0;
        while (done < quota) begin
            if ($urandom_range(0, 9) < 2) begin
                send_txn(rnd_noise(), 1'b0, none);
                done++;
            end
            else begin
                sh = ($urandom_range(0, 9) == 0) ? 31 : $urandom_range(12, 20);
                bx = rnd_coord(sh);
                by = rnd_coord(sh);
                if ($urandom_range(0, 4) != 0) begin
                    send_txn(mk(CMD_CLEAR, $urandom, $urandom, 0, 0, 0, 0), 1'b0, none);
                    done++;
                end
                k = ($urandom_range(0, 39) == 0) ? $urandom_range(250, 262)
                                                 : $urandom_range(1, 6);
                for (int i = 0; i < k; i++) begin
                    it = mk(CMD_APPEND, bx + rnd_coord(sh), by + rnd_coord(sh), 0, 0, 0, 0);
                    if (sh >= 31) it.x = $urandom;
                    send_txn(it, 1'b0, none);
                    done++;
                end
                for (int j = $urandom_range(1, 4); j > 0; j--) begin
                    it = mk(CMD_POSE, bx + rnd_coord(sh), by + rnd_coord(sh),
                            $signed(16'($urandom)) >>> 3, $signed(16'($urandom)) >>> 3,
                            $signed(16'($urandom)), $signed(16'($urandom)));
                    if ($urandom_range(0, 7) == 0) it = rnd_noise();
                    it.cmd = CMD_POSE;
                    send_txn(it, 1'b0, none);
                    it.cmd = CMD_COMPUTE;
                    send_txn(it, 1'b0, none);
                    done += 2;
                end
            end
        end
    endtask

    task automatic set_regs(logic [23:0] la, logic [23:0] gt,
                            logic [23:0] cs, logic [23:0] mt);
        settle();
        write_reg(REG_LOOKAHEAD, la);
        write_reg(REG_GOAL_TOL, gt);
        write_reg(REG_CRUISE, cs);
        write_reg(REG_MAX_TURN, mt);
    endtask

    initial
    begin
        row_t rows [$];
        steer_t none;
        in_valid  = 1'b0;
        command   = CMD_CLEAR;
        pos_x = 0; pos_y = 0;
        quat_x = 0; quat_y = 0; quat_z = 0; quat_w = 0;
        cfg_we = 1'b0; cfg_index = REG_LOOKAHEAD; cfg_data = 0;
        out_ready = 1'b0;
        out_stall = 0;
        calm = 1'b0;
        mismatches = 0; results_seen = 0; computes_sent = 0; items_sent = 0;
        path_len = 0; pose_x = 0; pose_y = 0; have_pose = 1'b0;
        for (int i = 0; i < 4; i++) ori[i] = 0;
        look_reg = 65536; tol_reg = 13107; cruise_reg = 32768; turn_reg = 65536;
        none = steer_make(0, 0, 0);
        rst_n = 1'b0;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed table: typed rows carry an obvious result
        rows.push_back('{mk(CMD_COMPUTE, 0, 0, 0, 0, 0, 0), 1, steer_make(0, 0, 0)});
        rows.push_back('{mk(CMD_POSE, 0, 0, 0, 0, 0, 32767), 0, none});
        rows.push_back('{mk(CMD_COMPUTE, 0, 0, 0, 0, 0, 0), 1, steer_make(1, 0, 0)});
        rows.push_back('{mk(CMD_APPEND, 32'h7fffffff, 32'h7fffffff, 0, 0, 0, 0), 0, none});
        rows.push_back('{mk(CMD_APPEND, -32'sh80000000, -32'sh80000000, 0, 0, 0, 0), 0, none});
        rows.push_back('{mk(CMD_COMPUTE, 0, 0, 0, 0, 0, 0), 0, none});
        rows.push_back('{mk(CMD_POSE, -64'sd2147483648, 2147483647,
                            -32768, -32768, -32768, -32768), 0, none});
        rows.push_back('{mk(CMD_COMPUTE, 0, 0, 0, 0, 0, 0), 0, none});
        rows.push_back('{mk(CMD_POSE, 2147483647, -64'sd2147483648,
                            32767, 32767, 32767, 32767), 0, none});
        rows.push_back('{mk(CMD_COMPUTE, 0, 0, 0, 0, 0, 0), 0, none});
        rows.push_back('{mk(CMD_CLEAR, 0, 0, 0, 0, 0, 0), 0, none});
        rows.push_back('{mk(CMD_APPEND, 65536, 0, 0, 0, 0, 0), 0, none});
        rows.push_back('{mk(CMD_APPEND, 131072, 65536, 0, 0, 0, 0), 0, none});
        rows.push_back('{mk(CMD_POSE, 0, 0, 0, 0, 0, 32767), 0, none});
        rows.push_back('{mk(CMD_COMPUTE, 0, 0, 0, 0, 0, 0), 0, none});
        // facing backwards: target lies behind
        rows.push_back('{mk(CMD_POSE, 0, 0, 0, 0, 32767, 0), 0, none});
        rows.push_back('{mk(CMD_COMPUTE, 0, 0, 0, 0, 0, 0), 0, none});
        // on the last waypoint: arrived
        rows.push_back('{mk(CMD_POSE, 131072, 65536, 0, 0, 0, 32767), 0, none});
        rows.push_back('{mk(CMD_COMPUTE, 0, 0, 0, 0, 0, 0), 1, steer_make(1, 0, 0)});
        // all-zero quaternion, yaw taken as zero
        rows.push_back('{mk(CMD_POSE, -20000, 30000, 0, 0, 0, 0), 0, none});
        rows.push_back('{mk(CMD_COMPUTE, 0, 0, 0, 0, 0, 0), 0, none});
        rows.push_back('{mk(CMD_POSE, 0, -40000, 0, 0, -30000, 10000), 0, none});
        rows.push_back('{mk(CMD_COMPUTE, 0, 0, 0, 0, 0, 0), 0, none});
        rows.push_back('{mk(CMD_CLEAR, 0, 0, 0, 0, 0, 0), 0, none});
        rows.push_back('{mk(CMD_COMPUTE, 0, 0, 0, 0, 0, 0), 1, steer_make(1, 0, 0)});
        foreach (rows[i]) send_txn(rows[i].it, rows[i].typed, rows[i].r);

        random_phase(150);
        set_regs(24'd1, 24'd1, 24'd0, 24'd1);
        random_phase(150);
        set_regs(24'hffffff, 24'hffffff, 24'hffffff, 24'hffffff);
        random_phase(100);
        // zero writes are dropped except for cruise speed
        set_regs(24'($urandom_range(1, 24'h3ffff)), 24'($urandom_range(1, 24'h7fff)),
                 24'($urandom), 24'($urandom_range(1, 24'h3ffff)));
        random_phase(150);
        set_regs(24'd0, 24'd0, 24'($urandom_range(1, 24'hfffff)), 24'd0);
        random_phase(150);
        set_regs(24'd98304, 24'd6553, 24'd65536, 24'd131072);
        random_phase(150);
        calm = 1'b1;
        random_phase(150);
        in_valid <= 1'b0;

        wait (steer_q.size() == 0);
        repeat (50) @(posedge clk);
        $display("%0d transactions in, %0d computes, %0d results, 6 register settings",
                 items_sent, computes_sent, results_seen);
        $display("%0d mismatches", mismatches);
        if (mismatches == 0 && steer_q.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        #20000000;
        $display("timeout with %0d results outstanding", steer_q.size());
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

>>> files.f
src/pps_pkg.sv
src/pps_divider.sv
src/pure_pursuit_steering_top.sv
sim/tb_pure_pursuit_steering_top.sv
